>>> hw/rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types and constants of the substring removal filter.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int PATTERN_MAX  = 8;
  localparam int WINDOW_DEPTH = 8;
  localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int LEN_W        = 4;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

endpackage

>>> hw/rtl/substring_removal_filter_core.sv
// ----------------------------------------------------------------------------
// substring_removal_filter_core
// Removes every non-overlapping occurrence of a configured byte pattern from
// a byte stream, with a look-ahead window as long as the pattern.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------
//   input   | in        | in_valid_i / in_ready_o    | in_item_i
//   result  | out       | out_valid_o / out_ready_i  | out_item_o
//   config  | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One byte per cycle in steady state while the result is not stalled; the
// window compare is the combinational path between the input register and
// the result register. At end of string the window drains one byte per
// cycle, then the end marker follows. Pending bytes above a shortened
// pattern length also drain one per cycle before the next byte is taken.
// Reset is asynchronous and clears control state and valid flags, not data.
// A stalled result holds the step; one more byte waits in the input register.
module substring_removal_filter_core
  import srf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] pat_bytes_q;
  logic [LEN_W-1:0]      pat_len_q;
  logic [LEN_W-1:0]      len_act;

  logic [7:0]       window_q [WINDOW_DEPTH];
  logic [7:0]       window_d [WINDOW_DEPTH];
  logic [7:0]       wnew     [WINDOW_DEPTH];
  logic [CNT_W-1:0] count_q, count_d, cnt_inc;
  logic             zero_seen_q, zero_seen_d;
  logic             flush_q, flush_d;
  logic             in_valid_q, in_valid_d;
  in_item_t         in_item_q, in_item_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic       out_free, consume, pre_pop, match;
  logic       emit_req;
  logic [7:0] emit_b;

  assign cfg_ready_o = 1'b1;
  assign len_act = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    consume     = 1'b0;
    emit_req    = 1'b0;
    emit_b      = window_q[0];
    count_d     = count_q;
    zero_seen_d = zero_seen_q;
    flush_d     = flush_q;
    window_d    = window_q;
    wnew        = window_q;
    match       = 1'b1;
    cnt_inc     = count_q + CNT_W'(1);
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;

    if (len_act == '0) begin
      pre_pop = (count_q != '0);
    end else begin
      pre_pop = (count_q >= CNT_W'(len_act));
    end

    // new byte written at the fill position, only used when no drain is due
    wnew[count_q[WIN_IDX_W-1:0]] = in_item_q.in_byte;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if ((LEN_W'(k) < len_act) && (wnew[k] != pat_bytes_q[8*k +: 8])) begin
        match = 1'b0;
      end
    end

    if (out_free) begin
      if (flush_q) begin
        if (count_q != '0) begin
          emit_req = 1'b1;
          emit_b   = window_q[0];
          for (int k = 0; k < WINDOW_DEPTH-1; k++) window_d[k] = window_q[k+1];
          count_d  = count_q - CNT_W'(1);
        end else begin
          out_valid_d = 1'b1;
          out_item_d  = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
          flush_d     = 1'b0;
          zero_seen_d = 1'b0;
        end
      end else if (in_valid_q) begin
        if (pre_pop) begin
          emit_req = 1'b1;
          emit_b   = window_q[0];
          for (int k = 0; k < WINDOW_DEPTH-1; k++) window_d[k] = window_q[k+1];
          count_d  = count_q - CNT_W'(1);
        end else begin
          consume = 1'b1;
          flush_d = in_item_q.in_last;
          if (len_act == '0) begin
            emit_req = 1'b1;
            emit_b   = in_item_q.in_byte;
          end else if (cnt_inc == CNT_W'(len_act)) begin
            if (match) begin
              count_d = '0;
            end else begin
              emit_req = 1'b1;
              emit_b   = wnew[0];
              for (int k = 0; k < WINDOW_DEPTH-1; k++) window_d[k] = wnew[k+1];
              count_d  = count_q;
            end
          end else begin
            window_d = wnew;
            count_d  = cnt_inc;
          end
        end
      end
    end

    // output stops at the first zero byte of the string
    if (emit_req && !zero_seen_q) begin
      if (emit_b == 8'h00) begin
        zero_seen_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_item_d  = '{out_byte: emit_b, out_valid: 1'b1, out_last: 1'b0};
      end
    end

    in_ready_o = !in_valid_q || consume;
    in_valid_d = in_valid_q && !consume;
    in_item_d  = in_item_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      count_q     <= '0;
      zero_seen_q <= 1'b0;
      flush_q     <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PATTERN_BYTES:  pat_bytes_q <= cfg_data_i;
          CFG_PATTERN_LENGTH: pat_len_q   <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      count_q     <= count_d;
      zero_seen_q <= zero_seen_d;
      flush_q     <= flush_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q   <= window_d;
    in_item_q  <= in_item_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hw/rtl/srf_checker.sv
// ----------------------------------------------------------------------------
// srf_checker
// Port-level checks of the substring removal filter, bound to the filter core.
// ----------------------------------------------------------------------------
module srf_checker
  import srf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // zero bytes end the string and are never passed on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_valid |-> out_item_o.out_byte != 8'h00)
    else $error("zero byte transferred as kept byte");

  // end marker carries no byte, and a kept byte is never the end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_last != out_item_o.out_valid) &&
                    (out_item_o.out_last ? (out_item_o.out_byte == 8'h00) : 1'b1))
    else $error("malformed end marker");

endmodule

bind substring_removal_filter_core srf_checker u_srf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
